/* hw/rtl/ccar_pkg.sv */
// Shared types and constants for the character cell attribute renderer.
package ccar_pkg;

   localparam int unsigned STORE_DEPTH = 6912;
   localparam int unsigned ADDR_W      = 13;

   localparam logic [ADDR_W-1:0] STORE_SIZE   = 13'd6912;
   localparam logic [ADDR_W-1:0] BITMAP_SIZE  = 13'd6144;
   localparam logic [4:0]        ROWS         = 5'd24;
   localparam logic [4:0]        LAST_COLUMN  = 5'd31;
   localparam logic [8:0]        SHIFT_X      = 9'd32;
   localparam logic [7:0]        SHIFT_Y      = 8'd24;
   localparam logic [5:0]        PERIOD_RESET = 6'd16;
   localparam logic [2:0]        LAST_LINE    = 3'd7;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_DRAW  = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [12:0] store_address;
      logic [7:0]  store_data;
      logic [4:0]  cell_row;
      logic [4:0]  cell_column;
   } ccar_req_type;

   typedef struct packed {
      logic [8:0]  screen_x;
      logic [7:0]  screen_y;
      logic [31:0] colour_run;
      logic        last_line;
   } ccar_rsp_type;

   typedef struct packed {
      logic       accept_write;
      logic       accept_draw;
      logic       load_attr;
      logic       rd_bitmap;
      logic [2:0] rd_line;
      logic       emit;
      logic [2:0] emit_line;
      logic       end_draw;
   } ccar_cmd_type;

endpackage

/* hw/rtl/char_cell_attribute_renderer_top.sv */
// Top level: character cell attribute renderer with attribute decode and flash.
// A write transaction leaves busy low, so the next transaction may follow at once.
// A draw transaction holds busy after accept while the controller steps through ST_ATTR and
// eight ST_LINE states (one attribute and eight bitmap reads on the single-port store); the
// next transaction is taken once busy falls. Its eight results strobe back to back and cannot be stalled.
// Synchronous reset clears the controller, flash counter, flash phase and period (16);
// the screen store keeps its contents and is not cleared.
module char_cell_attribute_renderer_top import ccar_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ccar_req_type req_payload,
   output logic         rsp_strobe,
   output ccar_rsp_type rsp_payload,
   input  logic         csr_we,
   input  logic [5:0]   csr_wdata
);

   ccar_cmd_type cmd;

   ccar_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .cmd         (cmd)
   );

   ccar_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last_line |=> rsp_strobe)
      else $error("result run broken before last line");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.last_line |=> !rsp_strobe)
      else $error("result strobe after last line");

   a_line_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last_line |=>
         rsp_payload.screen_y == $past(rsp_payload.screen_y) + 8'd1)
      else $error("scanline y did not advance by one");

   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_payload.opcode == OP_DRAW) && (req_payload.cell_row < ROWS)
      |=> busy)
      else $error("draw transaction accepted without going busy");

endmodule

/* hw/rtl/ccar_ctrl.sv */
// Controller: sequences the attribute read and eight bitmap reads of a draw.
module ccar_ctrl import ccar_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  ccar_req_type req_payload,
   output logic         busy,
   output ccar_cmd_type cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_ATTR, ST_LINE} state_type;

   state_type  state_ff;
   logic [2:0] line_ff;
   logic       idle;
   logic       draw_go;

   assign idle    = (state_ff == ST_IDLE);
   assign draw_go = start && idle && (req_payload.opcode == OP_DRAW)
                    && (req_payload.cell_row < ROWS);
   assign busy    = !idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         line_ff  <= 3'd0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               line_ff <= 3'd0;
               if (draw_go) state_ff <= ST_ATTR;
            end
            ST_ATTR: begin
               line_ff  <= 3'd0;
               state_ff <= ST_LINE;
            end
            ST_LINE: begin
               line_ff <= line_ff + 3'd1;
               if (line_ff == LAST_LINE) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
               line_ff  <= 3'd0;
            end
         endcase
      end
   end

   always_comb begin
      cmd              = '0;
      cmd.accept_write = start && idle && (req_payload.opcode == OP_WRITE);
      cmd.accept_draw  = draw_go;
      cmd.load_attr    = (state_ff == ST_ATTR);
      cmd.rd_bitmap    = (state_ff == ST_ATTR)
                         || ((state_ff == ST_LINE) && (line_ff != LAST_LINE));
      cmd.rd_line      = (state_ff == ST_ATTR) ? 3'd0 : line_ff + 3'd1;
      cmd.emit         = (state_ff == ST_LINE);
      cmd.emit_line    = line_ff;
      cmd.end_draw     = (state_ff == ST_LINE) && (line_ff == LAST_LINE);
   end

endmodule

/* hw/rtl/ccar_dp.sv */
// Datapath: screen store, attribute decode, colour runs and flash timing.
module ccar_dp import ccar_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ccar_req_type req_payload,
   input  ccar_cmd_type cmd,
   input  logic         csr_we,
   input  logic [5:0]   csr_wdata,
   output logic         rsp_strobe,
   output ccar_rsp_type rsp_payload
);

   logic [7:0] screen_store_ff [0:STORE_DEPTH-1];

   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        rd_data_ff;
   logic [4:0]        row_ff;
   logic [4:0]        col_ff;
   logic [3:0]        ink_ff, ink_in;
   logic [3:0]        paper_ff, paper_in;
   logic [5:0]        period_ff;
   logic [5:0]        count_ff, count_in;
   logic [5:0]        count_inc;
   logic              phase_ff, phase_in;
   logic              strobe_ff;
   ccar_rsp_type      rsp_ff, rsp_in;

   always_comb begin
      if (cmd.rd_bitmap) begin
         mem_addr = {row_ff[4:3], cmd.rd_line, row_ff[2:0], col_ff};
      end else if (cmd.accept_write) begin
         mem_addr = req_payload.store_address;
      end else begin
         mem_addr = BITMAP_SIZE + {3'd0, req_payload.cell_row, req_payload.cell_column};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_write && (req_payload.store_address < STORE_SIZE)) begin
         screen_store_ff[mem_addr] <= req_payload.store_data;
      end
      if (cmd.accept_draw || cmd.rd_bitmap) begin
         rd_data_ff <= screen_store_ff[mem_addr];
      end
   end

   // attribute: ink 2..0, paper 5..3, bright 6, flash 7
   always_comb begin
      ink_in   = {rd_data_ff[6], rd_data_ff[2:0]};
      paper_in = {rd_data_ff[6], rd_data_ff[5:3]};
      if (rd_data_ff[7] && phase_ff) begin
         ink_in   = {rd_data_ff[6], rd_data_ff[5:3]};
         paper_in = {rd_data_ff[6], rd_data_ff[2:0]};
      end
   end

   always_comb begin
      rsp_in           = rsp_ff;
      rsp_in.screen_x  = {1'b0, col_ff, 3'b000} + SHIFT_X;
      rsp_in.screen_y  = {row_ff, 3'b000} + {5'd0, cmd.emit_line} + SHIFT_Y;
      rsp_in.last_line = (cmd.emit_line == LAST_LINE);
      for (int i = 0; i < 8; i++) begin
         rsp_in.colour_run[31 - 4*i -: 4] = rd_data_ff[7 - i] ? ink_ff : paper_ff;
      end
   end

   always_comb begin
      count_inc = count_ff;
      if ((row_ff == 5'd0) && (col_ff == LAST_COLUMN)) count_inc = count_ff + 6'd1;
      count_in = count_inc;
      phase_in = phase_ff;
      if (count_inc >= period_ff) begin
         count_in = 6'd0;
         phase_in = !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_draw) begin
         row_ff <= req_payload.cell_row;
         col_ff <= req_payload.cell_column;
      end
      if (cmd.load_attr) begin
         ink_ff   <= ink_in;
         paper_ff <= paper_in;
      end
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         count_ff  <= 6'd0;
         phase_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_we) period_ff <= csr_wdata;
         if (cmd.end_draw) begin
            count_ff <= count_in;
            phase_ff <= phase_in;
         end
         strobe_ff <= cmd.emit;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* tb/sv/char_cell_render_checker.sv */
// Checker for the character cell renderer: predicts scanline colour runs and compares them.
`timescale 1ns / 1ps
module char_cell_render_checker import ccar_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  ccar_req_type req_payload,
   input  logic         rsp_strobe,
   input  ccar_rsp_type rsp_payload,
   input  logic         csr_we,
   input  logic [5:0]   csr_wdata,
   output int           fail_count,
   output int           pending_count
);

   logic [7:0]   screen_mem [0:STORE_DEPTH-1];
   logic [5:0]   frame_count;
   logic [5:0]   flash_period;
   logic         flash_on;
   int           fails = 0;
   ccar_rsp_type expected_lines[$];

   assign fail_count = fails;

   always @(posedge clock) begin
      ccar_rsp_type got;
      ccar_rsp_type want;
      logic [7:0]   attr;
      logic [7:0]   bits;
      logic [3:0]   ink;
      logic [3:0]   paper;
      logic [3:0]   swap;
      logic [3:0]   line;
      logic [31:0]  run;
      logic [4:0]   row;
      logic [4:0]   col;
      if (reset) begin
         expected_lines.delete();
         frame_count  = '0;
         flash_on     = 1'b0;
         flash_period = PERIOD_RESET;
      end else begin
         if (rsp_strobe) begin
            got = rsp_payload;
            if (expected_lines.size() == 0) begin
               $error("unexpected result: x %0d y %0d run %h", got.screen_x, got.screen_y,
                      got.colour_run);
               fails++;
            end else begin
               want = expected_lines.pop_front();
               if (got.screen_x !== want.screen_x) begin
                  $error("screen_x expected %0d got %0d", want.screen_x, got.screen_x);
                  fails++;
               end
               if (got.screen_y !== want.screen_y) begin
                  $error("screen_y expected %0d got %0d", want.screen_y, got.screen_y);
                  fails++;
               end
               if (got.colour_run !== want.colour_run) begin
                  $error("colour_run expected %h got %h", want.colour_run, got.colour_run);
                  fails++;
               end
               if (got.last_line !== want.last_line) begin
                  $error("last_line expected %0d got %0d", want.last_line, got.last_line);
                  fails++;
               end
            end
         end
         if (csr_we)
            flash_period = csr_wdata;
         if (start && !busy) begin
            if (req_payload.opcode == OP_WRITE) begin
               if (req_payload.store_address < STORE_SIZE)
                  screen_mem[req_payload.store_address] = req_payload.store_data;
            end else if (req_payload.cell_row < ROWS) begin
               row   = req_payload.cell_row;
               col   = req_payload.cell_column;
               attr  = screen_mem[BITMAP_SIZE + {3'd0, row, col}];
               ink   = {attr[6], attr[2:0]};
               paper = {attr[6], attr[5:3]};
               if (attr[7] && flash_on) begin
                  swap  = ink;
                  ink   = paper;
                  paper = swap;
               end
               for (line = 4'd0; line < 4'd8; line++) begin
                  bits = screen_mem[{row[4:3], line[2:0], row[2:0], col}];
                  run  = '0;
                  for (int i = 7; i >= 0; i--)
                     run = {run[27:0], bits[i] ? ink : paper};
                  want.screen_x   = {1'b0, col, 3'b000} + SHIFT_X;
                  want.screen_y   = {row, 3'b000} + {4'd0, line} + SHIFT_Y;
                  want.colour_run = run;
                  want.last_line  = (line[2:0] == LAST_LINE);
                  expected_lines.push_back(want);
               end
               if (row == 5'd0 && col == LAST_COLUMN)
                  frame_count = frame_count + 6'd1;
               if (frame_count >= flash_period) begin
                  flash_on    = !flash_on;
                  frame_count = '0;
               end
            end
         end
      end
      pending_count <= expected_lines.size();
   end

endmodule

/* tb/sv/tb_char_cell_attribute_renderer_top.sv */
// Testbench top for the character cell renderer: stimulus, reset, clock and verdict.
`timescale 1ns / 1ps
module tb_char_cell_attribute_renderer_top;
   import ccar_pkg::*;

   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 22;
   localparam int NUM_CELLS    = 8;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   ccar_req_type req_payload;
   logic         rsp_strobe;
   ccar_rsp_type rsp_payload;
   logic         csr_we;
   logic [5:0]   csr_wdata;
   int           fail_count;
   int           pending_count;
   logic         idle_on;
   logic [5:0]   periods [6];
   logic [4:0]   cell_rows [NUM_CELLS];
   logic [4:0]   cell_cols [NUM_CELLS];

   char_cell_attribute_renderer_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   char_cell_render_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_strobe    (rsp_strobe),
      .rsp_payload   (rsp_payload),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("char_cell_attribute_renderer_top: mismatch");
      $finish;
   end

   function automatic logic [12:0] attr_addr(logic [4:0] row, logic [4:0] col);
      return BITMAP_SIZE + {3'd0, row, col};
   endfunction

   function automatic logic [12:0] line_addr(logic [4:0] row, logic [4:0] col,
                                             logic [2:0] line);
      return {row[4:3], line, row[2:0], col};
   endfunction

   // unused fields carry random content
   function automatic ccar_req_type write_item(logic [12:0] addr, logic [7:0] data);
      ccar_req_type t;
      t               = $urandom;
      t.opcode        = OP_WRITE;
      t.store_address = addr;
      t.store_data    = data;
      t.cell_row      = 5'($urandom);
      t.cell_column   = 5'($urandom);
      return t;
   endfunction

   function automatic ccar_req_type draw_item(logic [4:0] row, logic [4:0] col);
      ccar_req_type t;
      t               = $urandom;
      t.opcode        = OP_DRAW;
      t.store_address = 13'($urandom);
      t.store_data    = 8'($urandom);
      t.cell_row      = row;
      t.cell_column   = col;
      return t;
   endfunction

   // draws only touch cells whose bytes were all written
   function automatic ccar_req_type random_item();
      int unsigned pick;
      logic [2:0]  c;
      pick = $urandom_range(0, 99);
      c    = 3'($urandom_range(0, NUM_CELLS - 1));
      if (pick < 45) begin
         if ($urandom_range(0, 9) == 0)
            return write_item(13'($urandom_range(6912, 8191)), 8'($urandom));
         if ($urandom_range(0, 1) == 0)
            return write_item(13'($urandom_range(0, 6911)), 8'($urandom));
         if ($urandom_range(0, 8) == 0)
            return write_item(attr_addr(cell_rows[c], cell_cols[c]), 8'($urandom));
         return write_item(line_addr(cell_rows[c], cell_cols[c], 3'($urandom)),
                           8'($urandom));
      end
      if (pick < 50)
         return draw_item(5'($urandom_range(24, 31)), 5'($urandom));
      if (pick < 72)
         return draw_item(5'd0, LAST_COLUMN);
      return draw_item(cell_rows[c], cell_cols[c]);
   endfunction

   task automatic send_transaction(ccar_req_type t);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_payload <= t;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(logic [5:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      idle_on     = 1'b1;
      periods     = '{6'd1, 6'd0, 6'd63, 6'd2, 6'd16, 6'd16};
      periods[4]  = 6'($urandom_range(3, 62));
      cell_rows   = '{5'd0, 5'd23, 5'd0, 5'd16, 5'd7, 5'd0, 5'd0, 5'd0};
      cell_cols   = '{5'd0, 5'd31, LAST_COLUMN, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      for (int k = 5; k < NUM_CELLS; k++) begin
         cell_rows[k[2:0]] = 5'($urandom_range(0, 23));
         cell_cols[k[2:0]] = 5'($urandom);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the bitmap and attribute bytes of every cell that is drawn
      for (int k = 0; k < NUM_CELLS; k++) begin
         for (int n = 0; n < 8; n++)
            send_transaction(write_item(line_addr(cell_rows[k[2:0]], cell_cols[k[2:0]],
                                                  n[2:0]), 8'($urandom)));
         send_transaction(write_item(attr_addr(cell_rows[k[2:0]], cell_cols[k[2:0]]),
                                     8'($urandom)));
      end

      send_transaction(write_item(13'd0, 8'hFF));
      send_transaction(write_item(13'd6911, 8'h00));
      send_transaction(write_item(BITMAP_SIZE, 8'hC7));
      send_transaction(write_item(BITMAP_SIZE + 13'd31, 8'hB8));
      send_transaction(write_item(13'd6912, 8'hFF));
      send_transaction(write_item(13'd8191, 8'h00));
      send_transaction(draw_item(5'd0, 5'd0));
      send_transaction(draw_item(5'd23, 5'd31));
      send_transaction(draw_item(5'd0, LAST_COLUMN));
      send_transaction(draw_item(5'd24, 5'd0));
      send_transaction(draw_item(5'd31, 5'd31));
      send_transaction(draw_item(5'd16, 5'd0));
      send_transaction(draw_item(5'd7, 5'd31));

      for (int p = 0; p < 6; p++) begin
         wait_idle();
         write_period(periods[p]);
         idle_on = (p != 5);
         repeat (PHASE_ITEMS) send_transaction(random_item());
      end
      wait_idle();

      if (fail_count == 0)
         $display("char_cell_attribute_renderer_top: match");
      else
         $display("char_cell_attribute_renderer_top: mismatch");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/ccar_pkg.sv
hw/rtl/ccar_ctrl.sv
hw/rtl/ccar_dp.sv
hw/rtl/char_cell_attribute_renderer_top.sv
tb/sv/char_cell_render_checker.sv
tb/sv/tb_char_cell_attribute_renderer_top.sv
